/* design/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define BMF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define BMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/bmf_pkg.sv */
// Shared types, constants and helpers of the box mean filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_WINDOW_DEF = 15;
  localparam int MAX_HEIGHT     = 4096;
  localparam int DIM_W          = 13;
  localparam int COL_W_MAX      = 12;
  localparam int ROWM_W_MAX     = 5;

  localparam logic [7:0] CFG_WINDOW_SIZE  = 8'd0;
  localparam logic [7:0] CFG_IMAGE_WIDTH  = 8'd1;
  localparam logic [7:0] CFG_IMAGE_HEIGHT = 8'd2;

  typedef struct packed {
    logic       first_of_frame;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [3:0]       window_size;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  // One accepted pixel: where it goes and which results it completes.
  typedef struct packed {
    logic [23:0]           pixel;
    logic [ROWM_W_MAX-1:0] wr_row;
    logic [COL_W_MAX-1:0]  wr_col;
    logic                  has_res;
    logic [11:0]           rlo;
    logic [11:0]           rhi;
    logic [ROWM_W_MAX-1:0] rlo_mod;
    logic [COL_W_MAX-1:0]  clo;
    logic [COL_W_MAX-1:0]  chi;
  } job_t;

  typedef enum logic [1:0] {
    MV_STAY = 2'd0,
    MV_UP   = 2'd1,
    MV_DN   = 2'd2
  } move_t;

  typedef struct packed {
    logic [DIM_W-1:0] y;
    logic             dn;
    move_t            mv;
  } walk_t;

  // One step of a reflect-101 walk over n samples in direction dn.
  function automatic walk_t walk(input logic [DIM_W-1:0] y, input logic dn,
                                 input logic [DIM_W-1:0] n);
    walk_t res;
    res.y  = y;
    res.dn = dn;
    res.mv = MV_STAY;
    if (n > DIM_W'(1)) begin
      if (!dn) begin
        if (y == n - DIM_W'(1)) begin
          res.dn = 1'b1;
          res.y  = y - DIM_W'(1);
          res.mv = MV_DN;
        end else begin
          res.y  = y + DIM_W'(1);
          res.mv = MV_UP;
        end
      end else begin
        if (y == '0) begin
          res.dn = 1'b0;
          res.y  = DIM_W'(1);
          res.mv = MV_UP;
        end else begin
          res.y  = y - DIM_W'(1);
          res.mv = MV_DN;
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/box_mean_filter_rgb.sv */
// Box mean filter for RGB raster streams, top level.
// Depends on bmf_pkg, bmf_front, bmf_queue, bmf_back, bmf_ram.
//
// Use:
//   in_*  : one pixel word per handshake, raster order; first_of_frame
//           restarts the position at row 0, column 0.
//   out_* : one filtered word per handshake with its row and column;
//           last_of_run marks the final result of one input pixel.
//   cfg_* : register writes (window size, width, height), always ready;
//           write only while the block is idle.
// Processing: each pixel is taken from the queue and stored in the line RAM.
//   For each result, with window side N (off = N/2), the window walk reads
//   one stored sample a cycle through the single read port of the line RAM,
//   then restoring division by the area gives the mean. The back end takes
//   the next pixel from the queue only once all results of the last are out.
// The pixel that completes a window passes through the queue and is stored
//   by the back end before the result of that window is computed.
// Reset clears position, queue, output valid flag and loads the default
//   registers (3, 1024, 768); the line RAM is not cleared.
// When out_ready is low the result holds in the output register; the
//   two-entry queue keeps taking pixels until full, then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module box_mean_filter_rgb #(
  parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = bmf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bmf_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bmf_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [7:0]    cfg_index,
  input  wire logic [12:0]   cfg_data
);

  bmf_pkg::cfg_t cfg;
  bmf_pkg::job_t new_job;
  bmf_pkg::job_t head_job;
  logic          q_full;
  logic          head_valid;
  logic          pop;
  logic          take;

  // Registers take a write every cycle.
  assign cfg_ready = 1'b1;
  // Accept a pixel whenever the queue has a free slot.
  assign in_ready  = !q_full;
  assign take      = in_valid && in_ready;

  bmf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_idx  (cfg_index),
    .cfg_wdata(cfg_data),
    .pix_take (take),
    .pix      (in_data),
    .cfg      (cfg),
    .job      (new_job)
  );

  bmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_job  (new_job),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  bmf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .job_valid(head_valid),
    .job      (head_job),
    .job_pop  (pop),
    .res_valid(out_valid),
    .res_ready(out_ready),
    .res      (out_data)
  );

endmodule

`default_nettype wire

/* design/bmf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/bmf_queue.sv */
// Two-entry queue of pixel jobs between front and back.
// Depends on bmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bmf_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output bmf_pkg::job_t      head_job
);

  bmf_pkg::job_t slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full       = cnt == 2'd2;
  assign head_valid = cnt != 2'd0;
  assign head_job   = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_job;
    end
  end

endmodule

`default_nettype wire

/* design/bmf_front.sv */
// Front end: configuration registers, pixel position, result span per pixel.
// Depends on bmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmf_front #(
  parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = bmf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_idx,
  input  wire logic [12:0]  cfg_wdata,
  input  wire logic         pix_take,
  input  wire bmf_pkg::in_t pix,
  output bmf_pkg::cfg_t     cfg,
  output bmf_pkg::job_t     job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_WINDOW);
  localparam int DW = bmf_pkg::DIM_W;
  localparam logic [RW-1:0] RM_LAST = RW'(MAX_WINDOW - 1);

  logic [3:0]    ws_reg;
  logic [10:0]   wid_reg;
  logic [12:0]   hgt_reg;
  logic [DW-1:0] w;
  logic [DW-1:0] h;
  logic [2:0]    off;

  logic [DW-1:0] row;
  logic [RW-1:0] rowm;
  logic [CW-1:0] col;

  logic [DW-1:0] r0, r1, r2, rn, row_next;
  logic [RW-1:0] m0, m1, m2, mn, rowm_next;
  logic [CW-1:0] c0, c1, col_next;
  logic [CW:0]   cn;
  logic signed [13:0] lo_r, lo_c;
  logic [6:0]    mtmp;

  assign w = (wid_reg == '0) ? DW'(1) :
             ({2'b0, wid_reg} > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : {2'b0, wid_reg};
  assign h = (hgt_reg == '0) ? DW'(1) :
             (hgt_reg > DW'(bmf_pkg::MAX_HEIGHT)) ? DW'(bmf_pkg::MAX_HEIGHT) : hgt_reg;
  assign off = ws_reg[3:1];

  assign cfg.window_size = ws_reg;
  assign cfg.width       = w;
  assign cfg.height      = h;

  always_comb begin
    c0 = pix.first_of_frame ? '0 : col;
    r0 = pix.first_of_frame ? '0 : row;
    m0 = pix.first_of_frame ? '0 : rowm;
    c1 = c0;
    r1 = r0;
    m1 = m0;
    if (DW'(c0) >= w) begin
      c1 = '0;
      r1 = r0 + DW'(1);
      m1 = (m0 == RM_LAST) ? '0 : m0 + RW'(1);
    end
    r2 = r1;
    m2 = m1;
    if (r1 >= h) begin
      r2 = '0;
      m2 = '0;
    end
    // advance to the next position
    cn        = {1'b0, c1} + (CW + 1)'(1);
    col_next  = cn[CW-1:0];
    row_next  = r2;
    rowm_next = m2;
    rn        = r2 + DW'(1);
    mn        = (m2 == RM_LAST) ? '0 : m2 + RW'(1);
    if (DW'(cn) >= w) begin
      col_next  = '0;
      row_next  = rn;
      rowm_next = mn;
      if (rn >= h) begin
        row_next  = '0;
        rowm_next = '0;
      end
    end
  end

  always_comb begin
    lo_r = $signed({1'b0, r2}) - $signed({11'b0, off});
    lo_c = $signed(14'(c1)) - $signed({11'b0, off});
    mtmp = 7'(m2) - 7'(off);
    if (mtmp[6]) begin
      mtmp = mtmp + 7'(MAX_WINDOW);
    end
    job.pixel   = {pix.red_in, pix.green_in, pix.blue_in};
    job.wr_row  = bmf_pkg::ROWM_W_MAX'(m2);
    job.wr_col  = bmf_pkg::COL_W_MAX'(c1);
    job.rlo_mod = lo_r[13] ? '0 : bmf_pkg::ROWM_W_MAX'(mtmp);
    if (r2 < h - DW'(1)) begin
      job.rlo = lo_r[11:0];
      job.rhi = lo_r[11:0];
    end else begin
      job.rlo = lo_r[13] ? '0 : lo_r[11:0];
      job.rhi = 12'(h - DW'(1));
    end
    if (DW'(c1) < w - DW'(1)) begin
      job.clo = lo_c[11:0];
      job.chi = lo_c[11:0];
    end else begin
      job.clo = lo_c[13] ? '0 : lo_c[11:0];
      job.chi = 12'(w - DW'(1));
    end
    job.has_res = ((r2 >= h - DW'(1)) || !lo_r[13]) &&
                  ((DW'(c1) >= w - DW'(1)) || !lo_c[13]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ws_reg  <= 4'd3;
      wid_reg <= 11'd1024;
      hgt_reg <= 13'd768;
      row     <= '0;
      rowm    <= '0;
      col     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          bmf_pkg::CFG_WINDOW_SIZE: begin
            if (cfg_wdata[0] && (int'(cfg_wdata[3:0]) <= MAX_WINDOW)) begin
              ws_reg <= cfg_wdata[3:0];
            end
          end
          bmf_pkg::CFG_IMAGE_WIDTH:  wid_reg <= cfg_wdata[10:0];
          bmf_pkg::CFG_IMAGE_HEIGHT: hgt_reg <= cfg_wdata;
          default: ;
        endcase
      end
      if (pix_take) begin
        row  <= row_next;
        rowm <= rowm_next;
        col  <= col_next;
      end
    end
  end

endmodule

`default_nettype wire

/* design/bmf_back.sv */
// Back end: stores each pixel, sums its completed windows from the line
// store, divides by the area and presents results. Depends on bmf_pkg, bmf_ram.
`timescale 1ns / 1ps
`default_nettype none

module bmf_back #(
  parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = bmf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bmf_pkg::cfg_t cfg,
  input  wire logic          job_valid,
  input  wire bmf_pkg::job_t job,
  output logic               job_pop,
  output logic               res_valid,
  input  wire logic          res_ready,
  output bmf_pkg::out_t      res
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_WINDOW);
  localparam int AW = RW + CW;
  localparam int DEPTH = MAX_WINDOW << CW;
  localparam int DW = bmf_pkg::DIM_W;
  localparam logic [RW-1:0] RM_LAST = RW'(MAX_WINDOW - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WRITE = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_SETUP = 8'b0000_1000,
    S_READ  = 8'b0001_0000,
    S_DRAIN = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t        state;
  bmf_pkg::job_t jb;
  logic [11:0]   r;
  logic [RW-1:0] rm;
  logic [CW-1:0] c;
  logic [DW-1:0] ry, cy, cy0;
  logic [RW-1:0] rym;
  logic          rdn, cdn, cdn0;
  logic [2:0]    k;
  logic [3:0]    i, j;
  logic          rd_pend;
  logic [15:0]   sr, sg, sb;
  logic [7:0]    qr, qg, qb;
  logic [2:0]    bitc;

  logic [2:0]     off;
  logic [3:0]     span;
  logic [7:0]     area;
  logic [15:0]    dv;
  bmf_pkg::walk_t rw_s, cw_s;
  logic [RW-1:0]  rym_s;
  logic [23:0]    rdata;
  logic           out_free;
  logic           last;

  assign off      = cfg.window_size[3:1];
  assign span     = {off, 1'b0};
  assign area     = {4'b0, cfg.window_size} * {4'b0, cfg.window_size};
  assign dv       = 16'(area) << bitc;
  assign rw_s     = bmf_pkg::walk(ry, rdn, cfg.height);
  assign cw_s     = bmf_pkg::walk(cy, cdn, cfg.width);
  assign out_free = !res_valid || res_ready;
  assign last     = (r == jb.rhi) && (c == jb.chi[CW-1:0]);
  assign job_pop  = (state == S_IDLE) && job_valid;

  always_comb begin
    case (rw_s.mv)
      bmf_pkg::MV_UP: rym_s = (rym == RM_LAST) ? '0 : rym + RW'(1);
      bmf_pkg::MV_DN: rym_s = (rym == '0) ? RM_LAST : rym - RW'(1);
      default:        rym_s = rym;
    endcase
  end

  bmf_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (state == S_WRITE),
    .waddr(AW'({jb.wr_row[RW-1:0], jb.wr_col[CW-1:0]})),
    .wdata(jb.pixel),
    .raddr(AW'({rym, cy[CW-1:0]})),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= state == S_READ;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: state <= jb.has_res ? S_PREP : S_IDLE;
        S_PREP:  state <= S_SETUP;
        S_SETUP: begin
          if (k == off) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (i == span && j == span) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_DIV;
        S_DIV: begin
          if (bitc == 3'd0) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            res_valid <= 1'b1;
            state     <= last ? S_IDLE : S_PREP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      sr <= sr + 16'(rdata[23:16]);
      sg <= sg + 16'(rdata[15:8]);
      sb <= sb + 16'(rdata[7:0]);
    end
    case (state)
      S_IDLE: begin
        jb <= job;
      end
      S_WRITE: begin
        r  <= jb.rlo;
        rm <= jb.rlo_mod[RW-1:0];
        c  <= jb.clo[CW-1:0];
      end
      S_PREP: begin
        // walk back from the centre by the offset, one sample a cycle
        ry  <= {1'b0, r};
        rym <= rm;
        rdn <= 1'b1;
        cy  <= DW'(c);
        cdn <= 1'b1;
        k   <= '0;
        sr  <= '0;
        sg  <= '0;
        sb  <= '0;
      end
      S_SETUP: begin
        if (k == off) begin
          rdn  <= ~rdn;
          cdn  <= ~cdn;
          cy0  <= cy;
          cdn0 <= ~cdn;
          i    <= '0;
          j    <= '0;
        end else begin
          ry  <= rw_s.y;
          rdn <= rw_s.dn;
          rym <= rym_s;
          cy  <= cw_s.y;
          cdn <= cw_s.dn;
          k   <= k + 3'd1;
        end
      end
      S_READ: begin
        if (j == span) begin
          j   <= '0;
          i   <= i + 4'd1;
          cy  <= cy0;
          cdn <= cdn0;
          ry  <= rw_s.y;
          rdn <= rw_s.dn;
          rym <= rym_s;
        end else begin
          j   <= j + 4'd1;
          cy  <= cw_s.y;
          cdn <= cw_s.dn;
        end
      end
      S_DRAIN: begin
        bitc <= 3'd7;
        qr   <= '0;
        qg   <= '0;
        qb   <= '0;
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle; quotient fits 8 bits
        if (sr >= dv) begin
          sr       <= sr - dv;
          qr[bitc] <= 1'b1;
        end
        if (sg >= dv) begin
          sg       <= sg - dv;
          qg[bitc] <= 1'b1;
        end
        if (sb >= dv) begin
          sb       <= sb - dv;
          qb[bitc] <= 1'b1;
        end
        bitc <= bitc - 3'd1;
      end
      S_EMIT: begin
        if (out_free) begin
          res.out_row     <= r;
          res.out_col     <= 10'(c);
          res.red_out     <= qr;
          res.green_out   <= qg;
          res.blue_out    <= qb;
          res.last_of_run <= last;
          if (c == jb.chi[CW-1:0]) begin
            c  <= jb.clo[CW-1:0];
            r  <= r + 12'd1;
            rm <= (rm == RM_LAST) ? '0 : rm + RW'(1);
          end else begin
            c <= c + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/bmf_checker.sv */
// Port-level checks of the box mean filter, bound to the top level.
// Depends on bmf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bmf_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire bmf_pkg::out_t out_data
);

  `BMF_ASSERT_ALWAYS(a_rst_out, clk, rst |=> !out_valid, "output valid after reset")
  `BMF_ASSERT_ALWAYS(a_rst_in, clk, rst |=> in_ready, "input not ready after reset")
  `BMF_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled word changed")

endmodule

bind box_mean_filter_rgb bmf_checker u_bmf_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
